// File: rtl/core/qfct_pkg.sv
// shared types and constants for the quad frustum cull test
package qfct_pkg;

    // plane register file and tested planes
    localparam int PLANE_COUNT = 4;
    localparam int PLANE_REGS  = 4;
    localparam int TEST_COUNT  = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // datapath widths
    localparam int COORD_W = 32;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int SUM_W   = 52;
    localparam int C_SHIFT = 15;

    // one packed plane register: a, b in Q2.14, c in Q16.16
    typedef struct packed {
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [COORD_W-1:0] c;
    } plane_t;

    // per-plane products of coefficients and quad terms
    typedef struct packed {
        logic signed [PROD_W-1:0] a_px;
        logic signed [PROD_W-1:0] b_py;
        logic signed [PROD_W-1:0] a_sx;
        logic signed [PROD_W-1:0] b_sy;
    } prod_t;

    // per-plane partial sums: center term and corner spread plus offset
    typedef struct packed {
        logic signed [SUM_W-1:0] center;
        logic signed [SUM_W-1:0] spread;
    } part_t;

endpackage

// File: rtl/core/qfct_plane_regs.sv
// plane register file written through the configuration port
module qfct_plane_regs
    import qfct_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_idx,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output plane_t [PLANE_REGS-1:0]      planes
);

    plane_t [PLANE_REGS-1:0] plane_reg;

    // register write, indexes beyond the file are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < PLANE_REGS; i++)
            begin
                if (cfg_we && (cfg_idx == CFG_IDX_W'(i)))
                begin
                    plane_reg[i] <= plane_t'(cfg_data);
                end
            end
        end
    end

    assign planes = plane_reg;

endmodule

// File: rtl/core/qfct_corner_mul.sv
// multiply stage: plane coefficients times quad center and size
module qfct_corner_mul
    import qfct_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_W-1:0]     px,
    input  logic signed [COORD_W-1:0]     py,
    input  logic signed [COORD_W-1:0]     sx,
    input  logic signed [COORD_W-1:0]     sy,
    input  plane_t [PLANE_REGS-1:0]       planes,
    output logic                          out_valid,
    output prod_t [TEST_COUNT-1:0]        prods
);

    logic                   valid_reg;
    prod_t [TEST_COUNT-1:0] prod_reg;
    prod_t [TEST_COUNT-1:0] prod_next;

    // four signed 16x32 products per plane
    always_comb
    begin
        for (int p = 0; p < TEST_COUNT; p++)
        begin
            prod_next[p].a_px = PROD_W'(planes[p].a) * PROD_W'(px);
            prod_next[p].b_py = PROD_W'(planes[p].b) * PROD_W'(py);
            prod_next[p].a_sx = PROD_W'(planes[p].a) * PROD_W'(sx);
            prod_next[p].b_sy = PROD_W'(planes[p].b) * PROD_W'(sy);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // product registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign prods     = prod_reg;

endmodule

// File: rtl/core/qfct_plane_eval.sv
// sum and sign stages: largest corner value per plane and cull decision
module qfct_plane_eval
    import qfct_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  prod_t [TEST_COUNT-1:0]       prods,
    input  plane_t [PLANE_REGS-1:0]      planes,
    output logic                         done,
    output logic                         culled
);

    logic                   valid_reg;
    part_t [TEST_COUNT-1:0] part_reg;
    part_t [TEST_COUNT-1:0] part_next;
    logic                   done_reg;
    logic                   culled_reg;
    logic                   culled_next;

    // the best corner takes each size term with the sign that makes it positive:
    // max = 2*a*px + 2*b*py + |a*sx| + |b*sy| + c*2^15
    always_comb
    begin
        logic signed [SUM_W-1:0] ax;
        logic signed [SUM_W-1:0] by;
        logic signed [SUM_W-1:0] abs_ax;
        logic signed [SUM_W-1:0] abs_by;
        logic signed [SUM_W-1:0] c_ext;
        for (int p = 0; p < TEST_COUNT; p++)
        begin
            ax     = SUM_W'(prods[p].a_sx);
            by     = SUM_W'(prods[p].b_sy);
            abs_ax = ax[SUM_W-1] ? -ax : ax;
            abs_by = by[SUM_W-1] ? -by : by;
            c_ext  = SUM_W'(planes[p].c);
            part_next[p].center = (SUM_W'(prods[p].a_px) + SUM_W'(prods[p].b_py)) <<< 1;
            part_next[p].spread = abs_ax + abs_by + (c_ext <<< C_SHIFT);
        end
    end

    // final add and sign test, culled when some plane has no positive corner
    always_comb
    begin
        logic signed [SUM_W-1:0] total;
        culled_next = 1'b0;
        for (int p = 0; p < TEST_COUNT; p++)
        begin
            total = part_reg[p].center + part_reg[p].spread;
            if (total <= 0)
            begin
                culled_next = 1'b1;
            end
        end
    end

    // valid bits and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            done_reg  <= valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        part_reg   <= part_next;
        culled_reg <= culled_next;
    end

    assign done   = done_reg;
    assign culled = culled_reg;

endmodule

// File: rtl/core/quad_frustum_cull_test.sv
// top level of the quad frustum cull test
//
//  channel   ports                                   beat taken when
//  -------   -------------------------------------   ---------------------
//  input     start, pos_x, pos_y, scale_x, scale_y   start && !busy
//  result    done, culled                            done (one cycle)
//  config    cfg_we, cfg_idx, cfg_data               cfg_we
//
// four register stages: input capture, multiply, partial sums, final sum and sign.
// one beat in per cycle; each beat passes through these stages in order. busy is always low.
// rst_n clears the valid bits and the plane registers (every quad culls until written).
// results cannot be held off, so the pipeline never stalls.
module quad_frustum_cull_test
    import qfct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] scale_x,
    input  logic signed [COORD_W-1:0] scale_y,
    output logic                      done,
    output logic                      culled,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_idx,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    plane_t [PLANE_REGS-1:0]   planes;
    prod_t  [TEST_COUNT-1:0]   prods;
    logic                      in_valid_reg;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic signed [COORD_W-1:0] sx_reg;
    logic signed [COORD_W-1:0] sy_reg;
    logic                      mul_valid;

    assign busy = 1'b0;

    // input capture valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    // input capture payload
    always_ff @(posedge clk)
    begin
        px_reg <= pos_x;
        py_reg <= pos_y;
        sx_reg <= scale_x;
        sy_reg <= scale_y;
    end

    // plane registers
    qfct_plane_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .planes   (planes)
    );

    // multiply stage
    qfct_corner_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .px        (px_reg),
        .py        (py_reg),
        .sx        (sx_reg),
        .sy        (sy_reg),
        .planes    (planes),
        .out_valid (mul_valid),
        .prods     (prods)
    );

    // sum and decision stages
    qfct_plane_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mul_valid),
        .prods    (prods),
        .planes   (planes),
        .done     (done),
        .culled   (culled)
    );

endmodule

// File: rtl/core/qfct_checker.sv
// port-level checker for the quad frustum cull test, bound to the top level
module qfct_checker
    import qfct_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic culled
);

    // every accepted beat is followed by a result strobe
    a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted beat produced no result");

    // no result without an earlier accepted beat
    a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without an accepted beat");

    // reset leaves no result on the ports
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !done)
        else $error("result strobe during reset");

    // result value is known whenever it is strobed
    a_culled_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(culled))
        else $error("unknown culled flag on a result");

endmodule

bind quad_frustum_cull_test qfct_checker u_qfct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .culled (culled)
);
